// File: rtl/servo_pose_interpolator_top_assert.svh
// ---------------------------------------------------------------------------
// Servo pose interpolator assertion macros
// Concurrent assertion shorthands used at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef SERVO_POSE_INTERPOLATOR_TOP_ASSERT_SVH
`define SERVO_POSE_INTERPOLATOR_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SPINT_ASSERT_IMP(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define SPINT_ASSERT_NXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/spint_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Servo pose interpolator package
// Field widths, reset values, opcodes, register indexes and sequencer states.
// ---------------------------------------------------------------------------
package spint_pkg;

    localparam int OP_W       = 3;
    localparam int IDX_IN_W   = 5;
    localparam int POS_W      = 12;
    localparam int ID_W       = 8;
    localparam int DUR_W      = 16;
    localparam int STEP_W     = 13;
    localparam int CNT_W      = 6;   // holds a servo count up to 32
    localparam int FRM_W      = DUR_W + 1;
    localparam int DIV_CNT_W  = $clog2(DUR_W);
    localparam int RESULT_CAP = 32;
    localparam int MAX_SERVOS_DEF = 32;

    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 8;
    localparam int FL_W       = 8;

    localparam int S_TDATA_W  = 48;  // 41 payload bits padded to bytes
    localparam int M_TDATA_W  = 24;  // 20 payload bits padded to bytes

    localparam logic [POS_W-1:0] POS_RESET = 12'd512;
    localparam logic [CNT_W-1:0] SC_RESET  = 6'd18;
    localparam logic [FL_W-1:0]  FL_RESET  = 8'd33;

    localparam logic [CFG_ADDR_W-1:0] CFG_SERVO_COUNT  = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_LENGTH = 1'd1;

    typedef enum logic [OP_W-1:0] {
        OP_SET_ID   = 3'd0,
        OP_LOAD_CUR = 3'd1,
        OP_LOAD_TGT = 3'd2,
        OP_START    = 3'd3,
        OP_TICK     = 3'd4
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FRAMES,   // duration / frame_length
        ST_FR_SET,
        ST_SD_RD,    // step size pass
        ST_SD_LOAD,
        ST_SD_RUN,
        ST_SD_WR,
        ST_TK_RD,    // position update pass
        ST_TK_UPD,
        ST_EM_RD,    // result pass
        ST_EM_LOAD
    } st_t;

endpackage

// File: rtl/servo_pose_interpolator_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Servo pose interpolator
// Linear pose interpolation over up to MAX_SERVOS slots with a shared divider.
// ---------------------------------------------------------------------------
// Set id, load current and load target are written as they are taken, and the
// block is ready again in the next cycle. A start runs one 16-step restoring
// divider, one quotient bit a cycle, to compute the frame count and then each
// servo's step in turn. A frame tick while moving updates the positions servo by
// servo through the single read port of the pose memories, then hands out one
// result per servo in use; the last result can still sit in the output register
// while the next transaction is already taken. Reset values of the pose, step
// and id memories come from per-entry valid bits, so there is no clearing pass
// after reset.
module servo_pose_interpolator_top #(
    parameter int MAX_SERVOS = spint_pkg::MAX_SERVOS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // tdata: servo_index[4:0], position_in[16:5], new_id[24:17], duration_ms[40:25]
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [spint_pkg::S_TDATA_W-1:0]   s_tdata,
    // tuser: opcode[2:0]
    input  logic [spint_pkg::OP_W-1:0]        s_tuser,
    // tdata: servo_id[7:0], position_out[19:8]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [spint_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                              m_tlast,
    // tuser: motion_done[0]
    output logic                              m_tuser,
    input  logic                              cfg_wr_en,
    input  logic [spint_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [spint_pkg::CFG_DATA_W-1:0]  cfg_wr_data
);
    import spint_pkg::*;

    localparam int IDX_W = (MAX_SERVOS > 1) ? $clog2(MAX_SERVOS) : 1;
    localparam int CAP   = (MAX_SERVOS < RESULT_CAP) ? MAX_SERVOS : RESULT_CAP;
    localparam logic [CNT_W-1:0]     CAP_C    = CNT_W'(CAP);
    localparam logic [IDX_IN_W+1:0]  MAX_C    = (IDX_IN_W + 2)'(MAX_SERVOS);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DUR_W - 1);

    // control
    st_t                   state_reg, state_next;
    logic                  moving_reg, moving_next;
    logic [CNT_W-1:0]      sc_reg, sc_next;
    logic [FL_W-1:0]       fl_reg, fl_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [MAX_SERVOS-1:0] cur_vld_reg, cur_vld_next;
    logic [MAX_SERVOS-1:0] tgt_vld_reg, tgt_vld_next;
    logic [MAX_SERVOS-1:0] step_vld_reg, step_vld_next;
    logic [MAX_SERVOS-1:0] id_vld_reg, id_vld_next;

    // datapath
    logic [FRM_W-1:0]      rem_reg, rem_next;
    logic [DUR_W-1:0]      quo_reg, quo_next;
    logic [FRM_W-1:0]      den_reg, den_next;
    logic [DIV_CNT_W-1:0]  dcnt_reg, dcnt_next;
    logic [FRM_W-1:0]      frames_reg, frames_next;
    logic                  all_done_reg, all_done_next;
    logic [ID_W-1:0]       m_id_reg, m_id_next;
    logic [POS_W-1:0]      m_pos_reg, m_pos_next;
    logic                  m_last_reg, m_last_next;
    logic                  m_done_reg, m_done_next;

    // memories
    logic [POS_W-1:0]  cur_mem  [MAX_SERVOS];
    logic [POS_W-1:0]  tgt_mem  [MAX_SERVOS];
    logic [STEP_W-1:0] step_mem [MAX_SERVOS];
    logic [ID_W-1:0]   id_mem   [MAX_SERVOS];
    logic [POS_W-1:0]  cur_q_reg, tgt_q_reg;
    logic [STEP_W-1:0] step_q_reg;
    logic [ID_W-1:0]   id_q_reg;
    logic              cur_qv_reg, tgt_qv_reg, step_qv_reg, id_qv_reg;

    logic              cur_we, tgt_we, step_we, id_we;
    logic [IDX_W-1:0]  cur_wa, wr_idx, mem_addr;
    logic [POS_W-1:0]  cur_wd;
    logic [STEP_W-1:0] step_wd;

    // read data after reset-value substitution
    logic [POS_W-1:0]  cur_rd, tgt_rd;
    logic [STEP_W-1:0] step_rd;
    logic [ID_W-1:0]   id_rd;

    // input fields
    logic [IDX_IN_W-1:0] in_idx;
    logic [POS_W-1:0]    in_pos;
    logic [ID_W-1:0]     in_nid;
    logic [DUR_W-1:0]    in_dur;
    op_t                 in_op;
    logic                s_acc, idx_ok, tgt_ok;

    logic [CNT_W-1:0]    n_act, cnt_inc;
    logic                cnt_last;
    logic [FL_W-1:0]     fl_eff;

    // shared divider step
    logic [FRM_W:0]      div_sh, div_diff;
    logic                div_fit;

    // move step
    logic                up, eq, snap, srv_done;
    logic [POS_W-1:0]    gap, new_cur;

    assign in_idx = s_tdata[IDX_IN_W-1:0];
    assign in_pos = s_tdata[16:5];
    assign in_nid = s_tdata[24:17];
    assign in_dur = s_tdata[40:25];
    assign in_op  = op_t'(s_tuser);

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;

    assign n_act    = (sc_reg > CAP_C) ? CAP_C : sc_reg;
    assign idx_ok   = ({2'b00, in_idx} < MAX_C);
    assign tgt_ok   = ({1'b0, in_idx} < n_act);
    assign wr_idx   = IDX_W'(in_idx);
    assign mem_addr = cnt_reg[IDX_W-1:0];
    assign cnt_inc  = cnt_reg + CNT_W'(1);
    assign cnt_last = (cnt_inc == n_act);
    assign fl_eff   = (fl_reg == '0) ? FL_W'(1) : fl_reg;

    assign cur_rd  = cur_qv_reg  ? cur_q_reg  : POS_RESET;
    assign tgt_rd  = tgt_qv_reg  ? tgt_q_reg  : POS_RESET;
    assign step_rd = step_qv_reg ? step_q_reg : '0;
    assign id_rd   = id_qv_reg   ? id_q_reg   : ID_W'(cnt_reg) + ID_W'(1);

    assign div_sh   = {rem_reg, quo_reg[DUR_W-1]};
    assign div_fit  = (div_sh >= {1'b0, den_reg});
    assign div_diff = div_sh - {1'b0, den_reg};

    assign up       = (tgt_rd > cur_rd);
    assign eq       = (tgt_rd == cur_rd);
    assign gap      = up ? (tgt_rd - cur_rd) : (cur_rd - tgt_rd);
    assign snap     = ({1'b0, gap} < step_rd);
    assign srv_done = eq || snap;
    always_comb begin
        if (eq) begin
            new_cur = cur_rd;
        end else if (snap) begin
            new_cur = tgt_rd;
        end else if (up) begin
            new_cur = cur_rd + step_rd[POS_W-1:0];
        end else begin
            new_cur = cur_rd - step_rd[POS_W-1:0];
        end
    end

    always_comb begin
        state_next    = state_reg;
        moving_next   = moving_reg;
        sc_next       = sc_reg;
        fl_next       = fl_reg;
        cnt_next      = cnt_reg;
        m_tvalid_next = m_tvalid_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        den_next      = den_reg;
        dcnt_next     = dcnt_reg;
        frames_next   = frames_reg;
        all_done_next = all_done_reg;
        m_id_next     = m_id_reg;
        m_pos_next    = m_pos_reg;
        m_last_next   = m_last_reg;
        m_done_next   = m_done_reg;
        cur_we        = 1'b0;
        tgt_we        = 1'b0;
        step_we       = 1'b0;
        id_we         = 1'b0;
        cur_wa        = wr_idx;
        cur_wd        = in_pos;
        step_wd       = STEP_W'(quo_reg) + STEP_W'(1);

        if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_SERVO_COUNT:  sc_next = cfg_wr_data[CNT_W-1:0];
                CFG_FRAME_LENGTH: fl_next = cfg_wr_data[FL_W-1:0];
                default: ;
            endcase
        end

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    case (in_op)
                        OP_SET_ID:   id_we  = idx_ok;
                        OP_LOAD_CUR: cur_we = idx_ok;
                        OP_LOAD_TGT: tgt_we = tgt_ok;
                        OP_START: begin
                            quo_next   = in_dur;
                            rem_next   = '0;
                            den_next   = FRM_W'(fl_eff);
                            dcnt_next  = '0;
                            state_next = ST_FRAMES;
                        end
                        OP_TICK: begin
                            if (moving_reg) begin
                                cnt_next      = '0;
                                all_done_next = 1'b1;
                                if (n_act == '0) begin
                                    moving_next = 1'b0;
                                end else begin
                                    state_next = ST_TK_RD;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_FRAMES, ST_SD_RUN: begin
                rem_next  = div_fit ? div_diff[FRM_W-1:0] : div_sh[FRM_W-1:0];
                quo_next  = {quo_reg[DUR_W-2:0], div_fit};
                dcnt_next = dcnt_reg + DIV_CNT_W'(1);
                if (dcnt_reg == DIV_LAST) begin
                    state_next = (state_reg == ST_FRAMES) ? ST_FR_SET : ST_SD_WR;
                end
            end
            ST_FR_SET: begin
                frames_next = {1'b0, quo_reg} + FRM_W'(1);
                cnt_next    = '0;
                if (n_act == '0) begin
                    moving_next = 1'b1;
                    state_next  = ST_IDLE;
                end else begin
                    state_next = ST_SD_RD;
                end
            end
            ST_SD_RD: state_next = ST_SD_LOAD;
            ST_SD_LOAD: begin
                quo_next   = DUR_W'(gap);
                rem_next   = '0;
                den_next   = frames_reg;
                dcnt_next  = '0;
                state_next = ST_SD_RUN;
            end
            ST_SD_WR: begin
                step_we  = 1'b1;
                cnt_next = cnt_inc;
                if (cnt_last) begin
                    moving_next = 1'b1;
                    state_next  = ST_IDLE;
                end else begin
                    state_next = ST_SD_RD;
                end
            end
            ST_TK_RD: state_next = ST_TK_UPD;
            ST_TK_UPD: begin
                cur_we        = 1'b1;
                cur_wa        = mem_addr;
                cur_wd        = new_cur;
                all_done_next = all_done_reg && srv_done;
                if (cnt_last) begin
                    cnt_next = '0;
                    if (all_done_reg && srv_done) begin
                        moving_next = 1'b0;
                    end
                    state_next = ST_EM_RD;
                end else begin
                    cnt_next   = cnt_inc;
                    state_next = ST_TK_RD;
                end
            end
            ST_EM_RD: state_next = ST_EM_LOAD;
            ST_EM_LOAD: begin
                // wait here until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_id_next     = id_rd;
                    m_pos_next    = cur_rd;
                    m_last_next   = cnt_last;
                    m_done_next   = all_done_reg;
                    cnt_next      = cnt_inc;
                    state_next    = cnt_last ? ST_IDLE : ST_EM_RD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cur_vld_next  = cur_vld_reg;
        tgt_vld_next  = tgt_vld_reg;
        step_vld_next = step_vld_reg;
        id_vld_next   = id_vld_reg;
        if (cur_we) begin
            cur_vld_next[cur_wa] = 1'b1;
        end
        if (tgt_we) begin
            tgt_vld_next[wr_idx] = 1'b1;
        end
        if (step_we) begin
            step_vld_next[mem_addr] = 1'b1;
        end
        if (id_we) begin
            id_vld_next[wr_idx] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            moving_reg   <= 1'b0;
            sc_reg       <= SC_RESET;
            fl_reg       <= FL_RESET;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            cur_vld_reg  <= '0;
            tgt_vld_reg  <= '0;
            step_vld_reg <= '0;
            id_vld_reg   <= '0;
        end else begin
            state_reg    <= state_next;
            moving_reg   <= moving_next;
            sc_reg       <= sc_next;
            fl_reg       <= fl_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
            cur_vld_reg  <= cur_vld_next;
            tgt_vld_reg  <= tgt_vld_next;
            step_vld_reg <= step_vld_next;
            id_vld_reg   <= id_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        den_reg      <= den_next;
        dcnt_reg     <= dcnt_next;
        frames_reg   <= frames_next;
        all_done_reg <= all_done_next;
        m_id_reg     <= m_id_next;
        m_pos_reg    <= m_pos_next;
        m_last_reg   <= m_last_next;
        m_done_reg   <= m_done_next;
    end

    // memory write ports
    always_ff @(posedge aclk) begin
        if (cur_we) begin
            cur_mem[cur_wa] <= cur_wd;
        end
        if (tgt_we) begin
            tgt_mem[wr_idx] <= in_pos;
        end
        if (step_we) begin
            step_mem[mem_addr] <= step_wd;
        end
        if (id_we) begin
            id_mem[wr_idx] <= in_nid;
        end
    end

    // registered reads at the sequencer's slot
    always_ff @(posedge aclk) begin
        cur_q_reg   <= cur_mem[mem_addr];
        tgt_q_reg   <= tgt_mem[mem_addr];
        step_q_reg  <= step_mem[mem_addr];
        id_q_reg    <= id_mem[mem_addr];
        cur_qv_reg  <= cur_vld_reg[mem_addr];
        tgt_qv_reg  <= tgt_vld_reg[mem_addr];
        step_qv_reg <= step_vld_reg[mem_addr];
        id_qv_reg   <= id_vld_reg[mem_addr];
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(M_TDATA_W - POS_W - ID_W)'(0), m_pos_reg, m_id_reg};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_done_reg;

    `include "servo_pose_interpolator_top_assert.svh"

    `SPINT_ASSERT_NXT(a_idle_tick_quiet, aclk, aresetn, s_acc && (s_tuser == OP_TICK) && !moving_reg, state_reg == ST_IDLE, "tick while idle started a pass")
    `SPINT_ASSERT_IMP(a_moving_rise, aclk, aresetn, $rose(moving_reg), $past(state_reg) == ST_SD_WR || $past(state_reg) == ST_FR_SET, "motion started outside a start sequence")
    `SPINT_ASSERT_IMP(a_step_range, aclk, aresetn, state_reg == ST_SD_WR, quo_reg[DUR_W-1:POS_W] == '0, "step quotient exceeds position range")

endmodule
